>>> hdl/infix_to_postfix_converter_defines.svh
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_defines.svh
// Assertion macros used by the checker file of the converter.
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define I2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define I2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/i2p_pkg.sv
// ---------------------------------------------------------------------------
// i2p_pkg
// Types, character codes and precedence shared by the converter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_INVALID  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_CLOSE    = 3'd3;
  localparam logic [2:0] ERR_OPEN     = 3'd4;

  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_ERR,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OP,
    KIND_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
    logic [2:0] err;
  } cmd_t;

  // 0 for anything that is not an operator ('(' included)
  function automatic logic [1:0] prec_f(logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_POW) p = 2'd3;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hdl/infix_to_postfix_converter.sv
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ---------------------------------------------------------------------------
// A letter or digit passes IDLE and EXEC from the command queue to its result,
// as does an invalid character, an unmatched bracket, or a push of '(' or
// of an operator onto an empty stack. An operator or ')' that meets a
// non-empty stack and pops nothing also passes TOP, for the read of the top.
// Each popped operator adds a LOOK state, after TOP or SEEK, since the stack
// sits in a RAM with registered read and every pop waits on a lookahead read
// of the entry below the top; the end marker adds TERM for its terminator.
// Whitespace is taken with no result. A 2-entry queue between input
// classification and the stack sequencer keeps the input accepting, until
// it fills, while pops are running or while a result waits on the output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  wire logic [0:0]  s_axis_tuser,   // [0] end_of_expr
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [10:8] error_code
  output logic             m_axis_tlast,   // last_of_run
  output logic [0:0]       m_axis_tuser    // [0] expr_done
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  i2p_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  i2p_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hdl/i2p_ram.sv
// ---------------------------------------------------------------------------
// i2p_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/i2p_front.sv
// ---------------------------------------------------------------------------
// i2p_front
// Accepts input characters, classifies them and queues commands (2 deep).
// ---------------------------------------------------------------------------
`default_nettype none

module i2p_front
  import i2p_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic [0:0] s_axis_tuser,   // [0] end_of_expr
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  cmd_t       cls;
  logic       skip;
  logic       push, pop;

  always_comb begin
    logic [7:0] c;
    c        = s_axis_tdata;
    skip     = 1'b0;
    cls.ch   = c;
    cls.err  = ERR_NONE;
    cls.kind = KIND_ERR;
    if (s_axis_tuser[0]) begin
      cls.kind = KIND_END;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      skip = 1'b1;
    end else if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
                 (c >= CH_LA && c <= CH_LZ)) begin
      cls.kind = KIND_CHAR;
    end else if (c == CH_OPEN) begin
      cls.kind = KIND_OPEN;
    end else if (c == CH_CLOSE) begin
      cls.kind = KIND_CLOSE;
    end else if (prec_f(c) != 2'd0) begin
      cls.kind = KIND_OP;
    end else begin
      cls.err = ERR_INVALID;
    end
  end

  assign s_axis_tready = (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && !skip;
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls;
  end

endmodule

`default_nettype wire

>>> hdl/i2p_back.sv
// ---------------------------------------------------------------------------
// i2p_back
// Operator stack sequencer: pushes, pops with one-entry lookahead, emits
// results through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module i2p_back
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  localparam int CW = $clog2(STACK_DEPTH + 1),
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  output logic             cmd_ready_o,
  input  wire cmd_t        cmd_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [10:8] error_code
  output logic             m_axis_tlast,   // last_of_run
  output logic [0:0]       m_axis_tuser    // [0] expr_done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TOP,
    ST_LOOK,
    ST_SEEK,
    ST_TERM
  } state_e;

  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d, open_q, open_d;
  logic [7:0]    cur_q, cur_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [2:0]    out_err_q, out_err_d;
  logic          out_last_q, out_last_d;
  logic          out_done_q, out_done_d;

  logic          slot_free;
  logic          emit;
  logic [7:0]    emit_char;
  logic [2:0]    emit_err;
  logic          emit_last, emit_done;
  logic          we;
  logic [CW-1:0] wsel, rsel;
  logic [7:0]    wdata, rdata;
  logic          have, more;

  // does stacked entry t leave the stack for this command
  function automatic logic pops_f(cmd_t c, logic [7:0] t);
    logic r;
    r = 1'b0;
    case (c.kind)
      KIND_OP:    r = (prec_f(t) > prec_f(c.ch)) ||
                      ((prec_f(t) == prec_f(c.ch)) && (c.ch != CH_POW));
      KIND_CLOSE: r = (t != CH_OPEN);
      KIND_END:   r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  i2p_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wsel[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(rsel[AW-1:0]),
    .rdata_o(rdata)
  );

  assign slot_free   = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == ST_IDLE);
  // EXEC fetches the top, TOP keeps it while the top stays on the stack;
  // every other state fetches the entry below the top
  assign rsel        = (state_q == ST_EXEC ||
                        (state_q == ST_TOP && !pops_f(cmd_q, rdata))) ?
                       cnt_q - CW'(1) : cnt_q - CW'(2);
  assign have        = (cnt_q >= CW'(2));
  assign more        = have && pops_f(cmd_q, rdata);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    open_d    = open_q;
    cur_d     = cur_q;
    emit      = 1'b0;
    emit_char = CH_NUL;
    emit_err  = ERR_NONE;
    emit_last = 1'b1;
    emit_done = 1'b0;
    we        = 1'b0;
    wsel      = cnt_q;
    wdata     = cmd_q.ch;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q.kind)
          KIND_CHAR: begin
            if (slot_free) begin
              emit      = 1'b1;
              emit_char = cmd_q.ch;
              state_d   = ST_IDLE;
            end
          end
          KIND_OPEN: begin
            if (cnt_q == FULL) begin
              if (slot_free) begin
                emit      = 1'b1;
                emit_err  = ERR_OVERFLOW;
                emit_done = 1'b1;
                cnt_d     = '0;
                open_d    = '0;
                state_d   = ST_IDLE;
              end
            end else begin
              we      = 1'b1;
              cnt_d   = cnt_q + CW'(1);
              open_d  = open_q + CW'(1);
              state_d = ST_IDLE;
            end
          end
          KIND_OP: begin
            if (cnt_q == '0) begin
              we      = 1'b1;
              cnt_d   = CW'(1);
              state_d = ST_IDLE;
            end else begin
              state_d = ST_TOP;
            end
          end
          KIND_CLOSE: begin
            if (open_q == '0) begin
              if (slot_free) begin
                emit      = 1'b1;
                emit_err  = ERR_CLOSE;
                emit_done = 1'b1;
                cnt_d     = '0;
                state_d   = ST_IDLE;
              end
            end else begin
              state_d = ST_TOP;
            end
          end
          KIND_END: begin
            if (open_q != '0) begin
              if (slot_free) begin
                emit      = 1'b1;
                emit_err  = ERR_OPEN;
                emit_done = 1'b1;
                cnt_d     = '0;
                open_d    = '0;
                state_d   = ST_IDLE;
              end
            end else if (cnt_q == '0) begin
              state_d = ST_TERM;
            end else begin
              state_d = ST_TOP;
            end
          end
          default: begin
            // invalid character from the front
            if (slot_free) begin
              emit      = 1'b1;
              emit_err  = cmd_q.err;
              emit_done = 1'b1;
              cnt_d     = '0;
              open_d    = '0;
              state_d   = ST_IDLE;
            end
          end
        endcase
      end
      ST_TOP: begin
        if (pops_f(cmd_q, rdata)) begin
          cur_d   = rdata;
          state_d = ST_LOOK;
        end else if (cmd_q.kind == KIND_CLOSE) begin
          // top is the matching '(' itself
          cnt_d   = cnt_q - CW'(1);
          open_d  = open_q - CW'(1);
          state_d = ST_IDLE;
        end else if (cnt_q == FULL) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_err  = ERR_OVERFLOW;
            emit_done = 1'b1;
            cnt_d     = '0;
            open_d    = '0;
            state_d   = ST_IDLE;
          end
        end else begin
          we      = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = cur_q;
          emit_last = (cmd_q.kind != KIND_END) && !more;
          cnt_d     = cnt_q - CW'(1);
          if (more) begin
            cur_d   = rdata;
            state_d = ST_SEEK;
          end else begin
            case (cmd_q.kind)
              KIND_OP: begin
                // push into the slot just freed
                we      = 1'b1;
                wsel    = cnt_q - CW'(1);
                cnt_d   = cnt_q;
                state_d = ST_IDLE;
              end
              KIND_CLOSE: begin
                cnt_d   = cnt_q - CW'(2);
                open_d  = open_q - CW'(1);
                state_d = ST_IDLE;
              end
              default: begin
                state_d = ST_TERM;
              end
            endcase
          end
        end
      end
      ST_SEEK: begin
        state_d = ST_LOOK;
      end
      ST_TERM: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_done = 1'b1;
          cnt_d     = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_err_d   = emit_err;
      out_last_d  = emit_last;
      out_done_d  = emit_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      cnt_q       <= '0;
      open_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_err_q   <= ERR_NONE;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      cnt_q       <= cnt_d;
      open_q      <= open_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_err_q   <= out_err_d;
      out_last_q  <= out_last_d;
      out_done_q  <= out_done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_err_q, out_char_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

endmodule

`default_nettype wire

>>> hdl/i2p_checker.sv
// ---------------------------------------------------------------------------
// i2p_checker
// Port-level checks on the converter's result stream, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_defines.svh"

module i2p_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [0:0]  m_axis_tuser
);

  // a stalled result holds
  `I2P_ASSERT_NXT(a_out_hold,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser),
    "result changed while stalled")

  // an expression ends only on the last result of its item
  `I2P_ASSERT_IMP(a_done_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast,
    "expr_done without last_of_run")

  // error results carry no character and end the expression
  `I2P_ASSERT_IMP(a_err_shape, m_axis_tvalid && m_axis_tdata[10:8] != 3'd0,
    m_axis_tdata[7:0] == 8'h00 && m_axis_tuser[0], "malformed error result")

  // ordinary results are error free, with the pad bits clear
  `I2P_ASSERT_IMP(a_ok_code, m_axis_tvalid,
    m_axis_tdata[15:11] == 5'd0 && (m_axis_tuser[0] || m_axis_tdata[10:8] == 3'd0),
    "bad code on result")

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);

`default_nettype wire
